// ===== hw/rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack calculator
// Request and response payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DIV_STEPS   = 48;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic [2:0] KIND_PUSH = 3'd0;
   localparam logic [2:0] KIND_ADD  = 3'd1;
   localparam logic [2:0] KIND_SUB  = 3'd2;
   localparam logic [2:0] KIND_MUL  = 3'd3;
   localparam logic [2:0] KIND_DIV  = 3'd4;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FEW      = 3'd1,
      ST_FULL     = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_FIX,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic signed [31:0]  operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  top_value;
      logic [4:0]          depth;
      logic [2:0]          status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator: Reverse Polish calculator on a bounded Q16.16 stack
// Pushes values, or pops two and pushes add/sub/mul/div of them, one request
// at a time, with a shared adder and a bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_data: kind, operand) is taken when req_valid and req_ready
//   are high at a clock edge; exactly one response (top value, depth, status)
//   follows on rsp_valid/rsp_ready. Requests are taken only while the
//   sequencer is idle, one at a time.
//   States passed from acceptance to rsp_valid, response register free:
//     push, refused or ignored request ........ S_RESP
//     add, subtract, multiply, divide by zero . S_READ, S_FIX, S_RESP
//     divide (non-zero divisor) ............... S_READ, S_DIV, S_FIX, S_RESP
//   In S_DIV the restoring divider resolves one quotient bit of the 48-bit
//   scaled dividend per cycle. The next request is taken in the cycle
//   rsp_valid rises.
//   The stack lives in a 16-entry memory with one write and one read port;
//   the top entry is also held in a register.
//   Reset empties the stack and drops any pending response. When the
//   receiver stalls, the response is held in its output register; a further
//   request may be taken, and its response waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rpn_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rpn_pkg::rsp_type      rsp_data
);
   import rpn_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic signed [31:0]  top_ff, top_in;
   logic [2:0]          kind_ff, kind_in;
   status_type          status_ff, status_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic [47:0]         quo_ff, quo_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [31:0]         mem [STACK_DEPTH];
   logic signed [31:0]  rd_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ADDR_W-1:0]   rd_addr;
   logic signed [31:0]  mem_wdata;

   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_load;

   logic                accept;
   logic                is_op;
   logic                last_step;
   logic signed [63:0]  sum;
   logic signed [63:0]  prod;
   logic signed [63:0]  mul_scaled;
   logic signed [63:0]  fix_val;
   logic signed [31:0]  res;
   logic                res_sat;
   logic [31:0]         first_mag, second_mag;
   logic [32:0]         shifted;
   logic [33:0]         trial;
   logic                trial_ge;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_op     = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB) ||
                      (kind_ff == KIND_MUL) || (kind_ff == KIND_DIV);
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   // stack memory: the entry below the top is read every cycle
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   // shared adder, multiplier and divider step
   assign sum  = 64'(rd_ff) + ((kind_ff == KIND_SUB) ? ~64'(top_ff) : 64'(top_ff))
                 + ((kind_ff == KIND_SUB) ? 64'sd1 : 64'sd0);
   assign prod = rd_ff * top_ff;

   assign first_mag  = rd_ff[31]  ? (~rd_ff + 32'd1)  : rd_ff;
   assign second_mag = top_ff[31] ? (~top_ff + 32'd1) : top_ff;

   assign shifted  = {rem_ff, quo_ff[47]};
   assign trial    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign trial_ge = !trial[33];

   // scale the product back, truncating toward zero
   assign mul_scaled = (acc_ff >>> 16) +
                       ((acc_ff[63] && (acc_ff[15:0] != 16'd0)) ? 64'sd1 : 64'sd0);
   assign fix_val    = (kind_ff == KIND_MUL) ? mul_scaled : acc_ff;

   always_comb begin
      res     = fix_val[31:0];
      res_sat = 1'b0;
      if (fix_val > 64'sd2147483647) begin
         res     = 32'sh7FFF_FFFF;
         res_sat = 1'b1;
      end else if (fix_val < -64'sd2147483648) begin
         res     = 32'sh8000_0000;
         res_sat = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (((req_data.kind == KIND_ADD) || (req_data.kind == KIND_SUB) ||
                    (req_data.kind == KIND_MUL) || (req_data.kind == KIND_DIV)) &&
                   (count_ff >= CNT_W'(2))) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: begin
            if ((kind_ff == KIND_DIV) && (top_ff != 32'sd0)) begin
               state_in = S_DIV;
            end else begin
               state_in = S_FIX;
            end
         end
         S_DIV: begin
            if (last_step) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and stack updates
   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      mem_we    = 1'b0;
      mem_waddr = ADDR_W'(count_ff);
      mem_wdata = req_data.operand;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_data.kind;
               status_in = ST_OK;
               if (req_data.kind == KIND_PUSH) begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     top_in   = req_data.operand;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (((req_data.kind == KIND_ADD) || (req_data.kind == KIND_SUB) ||
                             (req_data.kind == KIND_MUL) || (req_data.kind == KIND_DIV)) &&
                            (count_ff < CNT_W'(2))) begin
                  status_in = ST_FEW;
               end
            end
         end
         S_READ: begin
            priority if (kind_ff == KIND_MUL) begin
               acc_in = prod;
            end else if (kind_ff == KIND_DIV) begin
               if (top_ff == 32'sd0) begin
                  acc_in    = rd_ff[31] ? -64'sd2147483648 : 64'sd2147483647;
                  status_in = ST_DIVZERO;
               end else begin
                  quo_in  = {first_mag, 16'd0};
                  rem_in  = 32'd0;
                  dvs_in  = second_mag;
                  neg_in  = rd_ff[31] ^ top_ff[31];
                  step_in = '0;
               end
            end else begin
               acc_in = sum;
            end
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial[31:0] : shifted[31:0];
            quo_in  = {quo_ff[46:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               acc_in = neg_ff ? -$signed(64'({quo_ff[46:0], trial_ge}))
                               : $signed(64'({quo_ff[46:0], trial_ge}));
            end
         end
         S_FIX: begin
            // pop both operands, push the result in place of the first
            mem_we    = is_op;
            mem_waddr = rd_addr;
            mem_wdata = res;
            top_in    = res;
            count_in  = count_ff - CNT_W'(1);
            if (res_sat && (status_ff == ST_OK)) begin
               status_in = ST_OVERFLOW;
            end
         end
         S_RESP: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      step_ff   <= step_in;
   end

   // response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.top_value <= (count_ff == '0) ? 32'sd0 : top_ff;
         rsp_ff.depth     <= 5'(count_ff);
         rsp_ff.status    <= status_ff;
      end
   end

endmodule

`default_nettype wire

// ===== dv/rpn_stack_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb: self-checking bench for the RPN stack calculator
// A short table of directed requests covers the empty, full, divide-by-zero
// and saturation corners; random request streams then fill and drain the
// stack. Responses are checked per field against the table or a shadow stack.
// ----------------------------------------------------------------------------

module rpn_stack_calculator_tb;

   import rpn_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RANDOM_ITEMS = 1620;

   // Kinds the block treats as no-ops
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_1P5 = 32'sh0001_8000;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] operand;
      logic [4:0]         reps;
      logic               known;
      rsp_type            want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [16] = '{
      '{KIND_ADD,      32'sd0,           5'd1,  1'b1, '{32'sd0, 5'd0,  ST_FEW}},
      '{KIND_SPARE_LO, 32'sd0,           5'd1,  1'b1, '{32'sd0, 5'd0,  ST_OK}},
      '{KIND_PUSH,     Q_MAX,            5'd1,  1'b1, '{Q_MAX,  5'd1,  ST_OK}},
      '{KIND_SUB,      32'sd0,           5'd1,  1'b1, '{Q_MAX,  5'd1,  ST_FEW}},
      '{KIND_PUSH,     Q_1P5,            5'd13, 1'b0, '0},
      '{KIND_PUSH,     Q_MIN,            5'd1,  1'b1, '{Q_MIN,  5'd15, ST_OK}},
      '{KIND_PUSH,     32'sd0,           5'd1,  1'b1, '{32'sd0, 5'd16, ST_OK}},
      '{KIND_PUSH,     32'sh1234_5678,   5'd1,  1'b1, '{32'sd0, 5'd16, ST_FULL}},
      '{KIND_DIV,      32'sd0,           5'd1,  1'b1, '{Q_MIN,  5'd15, ST_DIVZERO}},
      '{KIND_SUB,      32'sd0,           5'd1,  1'b1, '{Q_MAX,  5'd14, ST_OVERFLOW}},
      '{KIND_MUL,      32'sd0,           5'd1,  1'b1, '{Q_MAX,  5'd13, ST_OVERFLOW}},
      '{KIND_DIV,      32'sd0,           5'd1,  1'b0, '0},
      '{KIND_PUSH,     32'sd0,           5'd1,  1'b1, '{32'sd0, 5'd13, ST_OK}},
      '{KIND_DIV,      32'sd0,           5'd1,  1'b1, '{Q_MAX,  5'd12, ST_DIVZERO}},
      '{KIND_ADD,      32'sd0,           5'd1,  1'b0, '0},
      '{KIND_SPARE_HI, 32'shFFFF_FFFF,   5'd1,  1'b0, '0}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] shadow_stack [STACK_DEPTH];
   int                 shadow_count = 0;
   rsp_type            pending_rsps [$];
   int                 mismatches   = 0;
   int                 rsp_seen     = 0;
   bit                 steady       = 1'b0;

   rpn_stack_calculator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the shadow stack and return the response it earns
   function automatic rsp_type apply_request(input req_type r);
      longint             first;
      longint             second;
      longint             exact;
      logic signed [31:0] res;
      status_type         st;
      rsp_type            o;
      st = ST_OK;
      if (r.kind == KIND_PUSH) begin
         if (shadow_count >= STACK_DEPTH) begin
            st = ST_FULL;
         end else begin
            shadow_stack[shadow_count] = r.operand;
            shadow_count++;
         end
      end else if (r.kind <= KIND_DIV) begin
         if (shadow_count < 2) begin
            st = ST_FEW;
         end else begin
            second = shadow_stack[shadow_count - 1];
            first  = shadow_stack[shadow_count - 2];
            case (r.kind)
               KIND_ADD: exact = first + second;
               KIND_SUB: exact = first - second;
               KIND_MUL: exact = (first * second) / 65536;
               default:  exact = (second != 0) ? (first * 65536) / second : 0;
            endcase
            if (r.kind == KIND_DIV && second == 0) begin
               res = (first < 0) ? Q_MIN : Q_MAX;
               st  = ST_DIVZERO;
            end else if (exact > longint'(Q_MAX)) begin
               res = Q_MAX;
               st  = ST_OVERFLOW;
            end else if (exact < longint'(Q_MIN)) begin
               res = Q_MIN;
               st  = ST_OVERFLOW;
            end else begin
               res = exact[31:0];
            end
            shadow_count--;
            shadow_stack[shadow_count - 1] = res;
         end
      end
      o.top_value = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
      o.depth     = shadow_count[4:0];
      o.status    = st;
      return o;
   endfunction

   // Offer one request from a falling edge; hold it until taken, then predict
   task automatic offer(input req_type r, input bit known, input rsp_type want,
                        output rsp_type pred);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pred = apply_request(r);
      pending_rsps.push_back(known ? want : pred);
      @(negedge clock);
   endtask

   initial begin : stimulus
      req_type            r;
      rsp_type            pred;
      logic [2:0]         kind;
      logic signed [31:0] op;
      int                 done_items;
      int                 loops;
      int                 push_pct;
      int                 roll;
      done_items = 0;
      loops      = 0;
      push_pct   = 50;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         r.kind    = DIRECTED[i].kind;
         r.operand = DIRECTED[i].operand;
         repeat (DIRECTED[i].reps) offer(r, DIRECTED[i].known, DIRECTED[i].want, pred);
      end

      while (done_items < RANDOM_ITEMS) begin
         // switch between balanced, filling and draining streams
         if (loops % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 50;
               1:       push_pct = 80;
               default: push_pct = 25;
            endcase
         end
         loops++;
         roll = $urandom_range(0, 99);
         if (roll < 4)
            kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         else if (roll < 4 + push_pct * 96 / 100)
            kind = KIND_PUSH;
         else
            kind = 3'($urandom_range(KIND_ADD, KIND_DIV));
         case ($urandom_range(0, 9))
            0, 1, 2: op = $urandom();
            3, 4, 5: op = (int'($urandom_range(0, 64)) - 32) * 65536
                          + int'($urandom_range(0, 65535));
            6:       op = '0;
            7:       op = Q_MAX;
            8:       op = Q_MIN;
            default: op = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
         endcase
         r.kind    = kind;
         r.operand = op;
         offer(r, 1'b0, '0, pred);
         done_items++;
         steady = (done_items >= 1000 && done_items < 1250);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         // hold off once for a long stretch so the block backs up
         if (!held && rsp_seen >= 500) begin
            held      = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsps.size() == 0) begin
            $error("unexpected response: top_value %0d depth %0d status %0d",
                   rsp_data.top_value, rsp_data.depth, rsp_data.status);
            mismatches++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.top_value !== want.top_value) begin
               $error("top_value: expected %0d, actual %0d",
                      want.top_value, rsp_data.top_value);
               mismatches++;
            end
            if (rsp_data.depth !== want.depth) begin
               $error("depth: expected %0d, actual %0d", want.depth, rsp_data.depth);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #(CLK_PERIOD * 600000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
